### hw/rtl/i2cm_pkg.sv
package i2cm_pkg;

	// Width of the bus delay counter and of the delay register.
	localparam int unsigned DELAY_WIDTH = 8;
	localparam int unsigned DELAY_RESET = 5;

	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_START   = 3'd1,
		CMD_RESTART = 3'd2,
		CMD_STOP    = 3'd3,
		CMD_READ    = 3'd4,
		CMD_WRITE   = 3'd5
	} cmd_t;

	typedef enum logic [4:0] {
		P_IDLE,
		P_RS_SDA_HI, P_RS_SCL_HI, P_RS_DELAY,
		P_ST_SDA_LO, P_ST_DELAY, P_ST_SCL_LO,
		P_W_SDA, P_W_SCL_HI, P_W_DELAY, P_W_SCL_LO,
		P_WA_RELEASE, P_WA_SCL_HI, P_WA_SAMPLE, P_WA_SCL_LO, P_WA_DRIVE_LO,
		P_R_RELEASE, P_R_DELAY, P_R_SCL_HI, P_R_SAMPLE, P_R_SCL_LO,
		P_RA_DRIVE, P_RA_SCL_HI, P_RA_DELAY, P_RA_SCL_LO, P_RA_SDA_LO,
		P_SP_SDA_LO, P_SP_DELAY1, P_SP_SCL_HI, P_SP_DELAY2, P_SP_SDA_HI, P_SP_DELAY3
	} phase_t;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] data_byte;
		logic       last_read;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic       ack_received;
		logic [7:0] read_byte;
	} res_t;

	function automatic logic is_delay(phase_t p);
		return (p == P_RS_DELAY) || (p == P_ST_DELAY) || (p == P_W_DELAY) ||
		       (p == P_R_DELAY) || (p == P_RA_DELAY) || (p == P_SP_DELAY1) ||
		       (p == P_SP_DELAY2) || (p == P_SP_DELAY3);
	endfunction

endpackage

### hw/rtl/i2cm_if.sv
interface i2cm_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [7:0] data_byte;
	logic       last_read;
	logic       sda_in;

	modport source (output valid, command, data_byte, last_read, sda_in, input ready);
	modport sink (input valid, command, data_byte, last_read, sda_in, output ready);
endinterface

interface i2cm_out_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       sda_release;
	logic       busy_res;
	logic       done_res;
	logic       ack_received;
	logic [7:0] read_byte;

	modport source (output valid, scl_out, sda_out, sda_release, busy_res, done_res,
		ack_received, read_byte, input ready);
	modport sink (input valid, scl_out, sda_out, sda_release, busy_res, done_res,
		ack_received, read_byte, output ready);
endinterface

interface i2cm_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### hw/rtl/i2c_master_byte_engine_top.sv
// Bit-banged I2C master byte engine. Every beat on req is one bus tick and may
// carry a command (start, restart, stop, read byte, write byte); every tick
// yields exactly one beat on rsp with the SCL/SDA levels after that tick, the
// busy and done flags, the last write's acknowledge and the last read byte.
// A command is only taken while the engine is idle; otherwise it is dropped.
// Throughput is one tick per clock cycle: a tick is latched in the input
// register, the sequencer works it out combinationally and writes the result
// register, which drives rsp. A stalled rsp holds the pipeline; req keeps
// flowing as long as the result register drains.
// cfg sets delay_ticks (reset 5, zero acts as one), the number of ticks held
// at each bus delay point; write it only while the engine is idle.
module i2c_master_byte_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	i2cm_in_if.sink     req,
	i2cm_out_if.source  rsp,
	i2cm_cfg_if.sink    cfg
);

	i2cm_pkg::item_t                    item_s1;
	logic                               valid_s1;
	i2cm_pkg::res_t                     res_c;
	i2cm_pkg::res_t                     res_q;
	logic                               out_valid_q;
	logic [i2cm_pkg::DELAY_WIDTH-1:0]   delay_q;
	logic                               adv;

	// The sequencer steps when a tick is latched and the result slot is free
	// or being emptied this cycle.
	assign adv       = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= i2cm_pkg::DELAY_WIDTH'(i2cm_pkg::DELAY_RESET);
		end else if (cfg.valid) begin
			delay_q <= i2cm_pkg::DELAY_WIDTH'(cfg.data);
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= '{command: req.command, data_byte: req.data_byte,
				last_read: req.last_read, sda_in: req.sda_in};
		end
	end

	i2cm_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.item        (item_s1),
		.delay_ticks (delay_q),
		.res         (res_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_c;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.scl_out      = res_q.scl_out;
	assign rsp.sda_out      = res_q.sda_out;
	assign rsp.sda_release  = res_q.sda_release;
	assign rsp.busy_res     = res_q.busy_res;
	assign rsp.done_res     = res_q.done_res;
	assign rsp.ack_received = res_q.ack_received;
	assign rsp.read_byte    = res_q.read_byte;

endmodule

### hw/rtl/i2cm_seq.sv
// Bus sequencer: one tick of the I2C master per step.
module i2cm_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  i2cm_pkg::item_t                     item,
	input  logic [i2cm_pkg::DELAY_WIDTH-1:0]    delay_ticks,
	output i2cm_pkg::res_t                      res
);

	i2cm_pkg::phase_t                   phase_q, ph_mid, ph_n;
	logic [3:0]                         bit_cnt_q, bc_n;
	logic [7:0]                         shift_q, sh_n;
	logic [i2cm_pkg::DELAY_WIDTH-1:0]   dly_q, dc_n, dc_dec, dly_load;
	logic                               scl_q, scl_n;
	logic                               sda_q, sda_n;
	logic                               rel_q, rel_n;
	logic                               ack_q, ack_n;
	logic                               nak_q, nak_n;
	logic [7:0]                         held_q, held_n;
	logic                               done;

	assign dly_load = (delay_ticks == '0) ? i2cm_pkg::DELAY_WIDTH'(1) : delay_ticks;
	assign dc_dec   = (dly_q != '0) ? dly_q - i2cm_pkg::DELAY_WIDTH'(1) : dly_q;

	always_comb begin
		ph_mid = phase_q;
		bc_n   = bit_cnt_q;
		sh_n   = shift_q;
		dc_n   = dly_q;
		scl_n  = scl_q;
		sda_n  = sda_q;
		rel_n  = rel_q;
		ack_n  = ack_q;
		nak_n  = nak_q;
		held_n = held_q;
		done   = 1'b0;

		// Command dispatch, only when idle.
		if (phase_q == i2cm_pkg::P_IDLE) begin
			unique case (item.command)
				i2cm_pkg::CMD_START: begin
					sh_n   = item.data_byte;
					ph_mid = i2cm_pkg::P_ST_SDA_LO;
				end
				i2cm_pkg::CMD_RESTART: begin
					sh_n   = item.data_byte;
					ph_mid = i2cm_pkg::P_RS_SDA_HI;
				end
				i2cm_pkg::CMD_STOP: begin
					ph_mid = i2cm_pkg::P_SP_SDA_LO;
				end
				i2cm_pkg::CMD_READ: begin
					nak_n  = item.last_read;
					ph_mid = i2cm_pkg::P_R_RELEASE;
				end
				i2cm_pkg::CMD_WRITE: begin
					sh_n   = item.data_byte;
					bc_n   = 4'd8;
					ph_mid = i2cm_pkg::P_W_SDA;
				end
				default: ;
			endcase
		end

		ph_n = ph_mid;
		unique case (ph_mid)
			i2cm_pkg::P_IDLE: ;
			i2cm_pkg::P_RS_SDA_HI: begin sda_n = 1'b1; ph_n = i2cm_pkg::P_RS_SCL_HI; end
			i2cm_pkg::P_RS_SCL_HI: begin scl_n = 1'b1; ph_n = i2cm_pkg::P_RS_DELAY; end
			i2cm_pkg::P_RS_DELAY: begin
				dc_n = dc_dec;
				if (dc_dec == '0) ph_n = i2cm_pkg::P_ST_SDA_LO;
			end
			i2cm_pkg::P_ST_SDA_LO: begin sda_n = 1'b0; ph_n = i2cm_pkg::P_ST_DELAY; end
			i2cm_pkg::P_ST_DELAY: begin
				dc_n = dc_dec;
				if (dc_dec == '0) ph_n = i2cm_pkg::P_ST_SCL_LO;
			end
			i2cm_pkg::P_ST_SCL_LO: begin
				scl_n = 1'b0;
				bc_n  = 4'd8;
				ph_n  = i2cm_pkg::P_W_SDA;
			end
			i2cm_pkg::P_W_SDA: begin sda_n = sh_n[7]; ph_n = i2cm_pkg::P_W_SCL_HI; end
			i2cm_pkg::P_W_SCL_HI: begin scl_n = 1'b1; ph_n = i2cm_pkg::P_W_DELAY; end
			i2cm_pkg::P_W_DELAY: begin
				dc_n = dc_dec;
				if (dc_dec == '0) ph_n = i2cm_pkg::P_W_SCL_LO;
			end
			i2cm_pkg::P_W_SCL_LO: begin
				scl_n = 1'b0;
				sh_n  = {sh_n[6:0], 1'b0};
				bc_n  = bc_n - 4'd1;
				ph_n  = (bc_n == 4'd0) ? i2cm_pkg::P_WA_RELEASE : i2cm_pkg::P_W_SDA;
			end
			i2cm_pkg::P_WA_RELEASE: begin
				rel_n = 1'b1;
				sda_n = 1'b1;
				ph_n  = i2cm_pkg::P_WA_SCL_HI;
			end
			i2cm_pkg::P_WA_SCL_HI: begin scl_n = 1'b1; ph_n = i2cm_pkg::P_WA_SAMPLE; end
			i2cm_pkg::P_WA_SAMPLE: begin
				ack_n = ~item.sda_in;
				ph_n  = i2cm_pkg::P_WA_SCL_LO;
			end
			i2cm_pkg::P_WA_SCL_LO: begin scl_n = 1'b0; ph_n = i2cm_pkg::P_WA_DRIVE_LO; end
			i2cm_pkg::P_WA_DRIVE_LO: begin
				rel_n = 1'b0;
				sda_n = 1'b0;
				ph_n  = i2cm_pkg::P_IDLE;
				done  = 1'b1;
			end
			i2cm_pkg::P_R_RELEASE: begin
				rel_n = 1'b1;
				sda_n = 1'b1;
				sh_n  = 8'h00;
				bc_n  = 4'd8;
				ph_n  = i2cm_pkg::P_R_DELAY;
			end
			i2cm_pkg::P_R_DELAY: begin
				dc_n = dc_dec;
				if (dc_dec == '0) ph_n = i2cm_pkg::P_R_SCL_HI;
			end
			i2cm_pkg::P_R_SCL_HI: begin scl_n = 1'b1; ph_n = i2cm_pkg::P_R_SAMPLE; end
			i2cm_pkg::P_R_SAMPLE: begin
				sh_n = {sh_n[6:0], item.sda_in};
				ph_n = i2cm_pkg::P_R_SCL_LO;
			end
			i2cm_pkg::P_R_SCL_LO: begin
				scl_n = 1'b0;
				bc_n  = bc_n - 4'd1;
				ph_n  = (bc_n == 4'd0) ? i2cm_pkg::P_RA_DRIVE : i2cm_pkg::P_R_DELAY;
			end
			i2cm_pkg::P_RA_DRIVE: begin
				held_n = sh_n;
				rel_n  = 1'b0;
				sda_n  = nak_n;
				ph_n   = i2cm_pkg::P_RA_SCL_HI;
			end
			i2cm_pkg::P_RA_SCL_HI: begin scl_n = 1'b1; ph_n = i2cm_pkg::P_RA_DELAY; end
			i2cm_pkg::P_RA_DELAY: begin
				dc_n = dc_dec;
				if (dc_dec == '0) ph_n = i2cm_pkg::P_RA_SCL_LO;
			end
			i2cm_pkg::P_RA_SCL_LO: begin scl_n = 1'b0; ph_n = i2cm_pkg::P_RA_SDA_LO; end
			i2cm_pkg::P_RA_SDA_LO: begin
				sda_n = 1'b0;
				ph_n  = i2cm_pkg::P_IDLE;
				done  = 1'b1;
			end
			i2cm_pkg::P_SP_SDA_LO: begin sda_n = 1'b0; ph_n = i2cm_pkg::P_SP_DELAY1; end
			i2cm_pkg::P_SP_DELAY1: begin
				dc_n = dc_dec;
				if (dc_dec == '0) ph_n = i2cm_pkg::P_SP_SCL_HI;
			end
			i2cm_pkg::P_SP_SCL_HI: begin scl_n = 1'b1; ph_n = i2cm_pkg::P_SP_DELAY2; end
			i2cm_pkg::P_SP_DELAY2: begin
				dc_n = dc_dec;
				if (dc_dec == '0) ph_n = i2cm_pkg::P_SP_SDA_HI;
			end
			i2cm_pkg::P_SP_SDA_HI: begin sda_n = 1'b1; ph_n = i2cm_pkg::P_SP_DELAY3; end
			i2cm_pkg::P_SP_DELAY3: begin
				dc_n = dc_dec;
				if (dc_dec == '0) begin
					ph_n = i2cm_pkg::P_IDLE;
					done = 1'b1;
				end
			end
		endcase

		// Entering a hold point reloads the tick counter.
		if (i2cm_pkg::is_delay(ph_n) && !i2cm_pkg::is_delay(ph_mid)) dc_n = dly_load;

		res.scl_out      = scl_n;
		res.sda_out      = rel_n ? 1'b1 : sda_n;
		res.sda_release  = rel_n;
		res.busy_res     = (ph_n != i2cm_pkg::P_IDLE);
		res.done_res     = done;
		res.ack_received = ack_n;
		res.read_byte    = held_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= i2cm_pkg::P_IDLE;
			bit_cnt_q <= 4'd0;
			shift_q   <= 8'h00;
			dly_q     <= '0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			rel_q     <= 1'b0;
			ack_q     <= 1'b0;
			nak_q     <= 1'b0;
			held_q    <= 8'h00;
		end else if (step) begin
			phase_q   <= ph_n;
			bit_cnt_q <= bc_n;
			shift_q   <= sh_n;
			dly_q     <= dc_n;
			scl_q     <= scl_n;
			sda_q     <= sda_n;
			rel_q     <= rel_n;
			ack_q     <= ack_n;
			nak_q     <= nak_n;
			held_q    <= held_n;
		end
	end

endmodule
